[hw/rtl/contiguous_block_allocator_core_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBA_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define CBA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("allocator check failed");

`endif

[hw/rtl/cba_pkg.sv]
// Shared types and constants for the contiguous block allocator.
package cba_pkg;

   // Fixed field widths
   localparam int LEN_W   = 7;
   localparam int HINT_W  = 6;
   localparam int START_W = 6;
   localparam int SIZE_W  = 7;

   // Disk size register value after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_DONE
   } state_type;

   // Controls from the sequencer to the bitmap ring
   typedef struct packed {
      logic shift;
      logic mark;
   } chain_ctl_type;

endpackage

[hw/rtl/cba_cell.sv]
// One bitmap cell: holds the used bit of one block and passes it along the ring.
module cba_cell (
   input  logic clock,
   input  logic reset,
   input  logic shift_en,
   input  logic set_en,
   input  logic next_bit,
   output logic used_bit
);

   logic used_ff;
   logic used_in;

   // Take the neighbor's bit on a shift, setting it when the block is claimed
   always_comb begin
      if (shift_en) begin
         used_in = next_bit | set_en;
      end else begin
         used_in = used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign used_bit = used_ff;

endmodule

[hw/rtl/cba_ctrl.sv]
// Sequencer: scans the rotating bitmap for a free run, then marks it.
module cba_ctrl #(
   parameter int NUM_BLOCKS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cba_pkg::LEN_W-1:0]      req_request_blocks,
   input  logic [cba_pkg::HINT_W-1:0]     req_start_hint,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_granted,
   output logic [cba_pkg::START_W-1:0]    rsp_start_block,
   input  logic [cba_pkg::SIZE_W-1:0]     disk_blocks,
   input  logic                           head_bit,
   output cba_pkg::chain_ctl_type         chain_ctl
);
   import cba_pkg::*;

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int SW    = CW + 1;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_BLOCKS - 1);
   localparam logic [SW-1:0]    NUM_EXT  = SW'(NUM_BLOCKS);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [HINT_W-1:0]   hint_ff, hint_in;
   logic [LEN_W-1:0]    run0_ff, run0_in;
   logic [LEN_W-1:0]    runh_ff, runh_in;
   logic                found0_ff, found0_in;
   logic                foundh_ff, foundh_in;
   logic [IDX_W-1:0]    start0_ff, start0_in;
   logic [IDX_W-1:0]    starth_ff, starth_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [START_W-1:0]  rsp_start_ff, rsp_start_in;

   logic                accept;
   logic                scan_en;
   logic                load_rsp;
   logic                last_pos;
   logic [SW-1:0]       size_ext;
   logic [SW-1:0]       n_ext;
   logic [SW-1:0]       pos_ext;
   logic [SW-1:0]       len_ext;
   logic                active;
   logic                past_hint;
   logic [LEN_W-1:0]    run0_next;
   logic [LEN_W-1:0]    runh_next;
   logic [IDX_W-1:0]    cand_start;
   logic                granted;
   logic [IDX_W-1:0]    sel_start;
   logic [SW-1:0]       sel_ext;
   logic                mark_hit;

   // Effective disk size, saturated to the ring length
   assign size_ext = SW'(disk_blocks);
   assign n_ext    = (size_ext > NUM_EXT) ? NUM_EXT : size_ext;

   // Block currently at the head of the ring
   assign pos_ext   = SW'(pos_ff);
   assign len_ext   = SW'(len_ff);
   assign active    = pos_ext < n_ext;
   assign past_hint = pos_ext >= SW'(hint_ff);
   assign last_pos  = pos_ff == LAST_POS;

   // Free-run counters for the search from zero and from the hint
   assign run0_next  = head_bit ? '0 : run0_ff + 1'b1;
   assign runh_next  = head_bit ? '0 : runh_ff + 1'b1;
   assign cand_start = IDX_W'(pos_ext + SW'(1) - len_ext);

   // Hint search wins, zero search is the fallback
   assign granted   = foundh_ff | found0_ff;
   assign sel_start = foundh_ff ? starth_ff : (found0_ff ? start0_ff : '0);
   assign sel_ext   = SW'(sel_start);
   assign mark_hit  = granted && (pos_ext >= sel_ext) && (pos_ext < sel_ext + len_ext);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_pos) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (last_pos) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready       = 1'b0;
      scan_en         = 1'b0;
      load_rsp        = 1'b0;
      chain_ctl.shift = 1'b0;
      chain_ctl.mark  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SCAN: begin
            scan_en         = 1'b1;
            chain_ctl.shift = 1'b1;
         end
         ST_MARK: begin
            chain_ctl.shift = 1'b1;
            chain_ctl.mark  = mark_hit;
         end
         ST_DONE: load_rsp = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   // Datapath next values
   always_comb begin
      pos_in         = pos_ff;
      len_in         = len_ff;
      hint_in        = hint_ff;
      run0_in        = run0_ff;
      runh_in        = runh_ff;
      found0_in      = found0_ff;
      foundh_in      = foundh_ff;
      start0_in      = start0_ff;
      starth_in      = starth_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_start_in   = rsp_start_ff;

      // Ring position follows the shifts and wraps after one revolution
      if (chain_ctl.shift) begin
         pos_in = last_pos ? '0 : pos_ff + 1'b1;
      end

      // Latch the request and clear the search
      if (accept) begin
         len_in    = req_request_blocks;
         hint_in   = req_start_hint;
         run0_in   = '0;
         runh_in   = '0;
         found0_in = 1'b0;
         foundh_in = 1'b0;
      end

      // Both searches run in the same revolution; a zero length never matches
      if (scan_en && active && (len_ff != '0)) begin
         if (!found0_ff) begin
            run0_in = run0_next;
            if (run0_next == len_ff) begin
               found0_in = 1'b1;
               start0_in = cand_start;
            end
         end
         if (!foundh_ff && past_hint) begin
            runh_in = runh_next;
            if (runh_next == len_ff) begin
               foundh_in = 1'b1;
               starth_in = cand_start;
            end
         end
      end

      // Output register
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = granted;
         rsp_start_in   = START_W'(sel_start);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         found0_ff    <= 1'b0;
         foundh_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         found0_ff    <= found0_in;
         foundh_ff    <= foundh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff         <= len_in;
      hint_ff        <= hint_in;
      run0_ff        <= run0_in;
      runh_ff        <= runh_in;
      start0_ff      <= start0_in;
      starth_ff      <= starth_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_start_ff   <= rsp_start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_start_block = rsp_start_ff;

endmodule

[hw/rtl/contiguous_block_allocator_core.sv]
// Top level of the contiguous block allocator: bitmap ring, sequencer, size register.
//
// Usage:
//   req_* carries one allocation request (run length, start hint) with valid/ready.
//   rsp_* returns one result per request (granted, first block) with valid/ready.
//   csr_wr_en/csr_wr_data set the disk size in blocks; write only while idle.
// Operation:
//   The used bits sit in a ring of NUM_BLOCKS cells that rotates one cell per
//   cycle while the sequencer scans or marks. One revolution scans for a free
//   run from the hint and from block 0 at once, a second revolution marks the
//   chosen run, and the result is then loaded into the output register.
//   One request is in work at a time.
// Reset:
//   All blocks free, disk size 64, no result pending.
// Stalls:
//   The result sits in an output register; a new request is taken while it
//   waits. A later result is held back until the earlier one is transferred.
`include "contiguous_block_allocator_core_assert.svh"

module contiguous_block_allocator_core #(
   parameter int NUM_BLOCKS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cba_pkg::LEN_W-1:0]     req_request_blocks,
   input  logic [cba_pkg::HINT_W-1:0]    req_start_hint,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_granted,
   output logic [cba_pkg::START_W-1:0]   rsp_start_block,
   input  logic                          csr_wr_en,
   input  logic [cba_pkg::SIZE_W-1:0]    csr_wr_data
);
   import cba_pkg::*;

   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [NUM_BLOCKS-1:0] used_w;
   chain_ctl_type         chain_ctl;

   // Disk size register
   assign size_in = csr_wr_en ? csr_wr_data : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // Bitmap ring: each cell takes its upper neighbor, the tail takes the head
   for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
      if (k == NUM_BLOCKS - 1) begin : g_tail
         cba_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (chain_ctl.shift),
            .set_en   (chain_ctl.mark),
            .next_bit (used_w[0]),
            .used_bit (used_w[k])
         );
      end else begin : g_body
         cba_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (chain_ctl.shift),
            .set_en   (1'b0),
            .next_bit (used_w[k+1]),
            .used_bit (used_w[k])
         );
      end
   end

   // Search and mark sequencer
   cba_ctrl #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_request_blocks (req_request_blocks),
      .req_start_hint     (req_start_hint),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_granted        (rsp_granted),
      .rsp_start_block    (rsp_start_block),
      .disk_blocks        (size_ff),
      .head_bit           (used_w[0]),
      .chain_ctl          (chain_ctl)
   );

   // Checks
   `CBA_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)
   `CBA_ASSERT_SAME(a_refused_start_zero, clock, reset, rsp_valid && !rsp_granted,
                    rsp_start_block == '0)
   `CBA_ASSERT_SAME(a_mark_while_rotating, clock, reset, chain_ctl.mark, chain_ctl.shift)
   `CBA_ASSERT_SAME(a_no_transfer_while_rotating, clock, reset, chain_ctl.shift, !req_ready)

endmodule
